// File: src/gjls_pkg.sv
// shared types and constants for the gauss-jordan solver
// no dependencies
`default_nettype none
package gjls_pkg;
	localparam int MaxRows = 16;
	localparam int MaxCols = 32;
	localparam int RowW = $clog2(MaxRows);
	localparam int ColW = $clog2(MaxCols);
	localparam int AddrW = RowW + ColW;

	localparam logic [1:0] RegRows = 2'd0;
	localparam logic [1:0] RegCols = 2'd1;
	localparam logic [1:0] RegThr  = 2'd2;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_COL,
		ST_SRCH_RD,
		ST_SRCH,
		ST_PIV,
		ST_SWAP_RD,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_DIAG_RD,
		ST_DIAG,
		ST_DIV_RD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ROW,
		ST_FAC_RD,
		ST_FAC,
		ST_MS_RD,
		ST_MS_MUL,
		ST_MS_WR,
		ST_OUT_RD,
		ST_OUT
	} gjls_state_t;

	// saturate a 64 bit value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// magnitude of a 32 bit word, 33 bits wide
	function automatic logic [32:0] mag33(input logic signed [31:0] v);
		logic signed [32:0] w;
		w = {v[31], v};
		return w[32] ? 33'(-w) : 33'(w);
	endfunction
endpackage
`default_nettype wire

// File: src/gjls_div.sv
// iterative signed divider: sat32((a * 65536) / d), truncated toward zero
// depends on gjls_pkg
`default_nettype none
module gjls_div
	import gjls_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [31:0] num,
	input  wire logic signed [31:0] den,
	output logic                    done,
	output logic signed [31:0]      quo
);
	localparam int NW = 48;
	logic [NW-1:0] n_q;
	logic [32:0]   d_q;
	logic [33:0]   rem_q;
	logic [NW-1:0] qt_q;
	logic          neg_q, busy_q;
	logic [5:0]    cnt_q;
	logic [33:0]   trial;
	logic [32:0]   an;
	logic signed [63:0] sq;

	assign an = mag33(num);
	assign trial = {rem_q[32:0], n_q[NW-1]} - {1'b0, d_q};
	assign sq = neg_q ? -$signed({16'd0, qt_q}) : $signed({16'd0, qt_q});
	assign quo = sat32(sq);

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q <= {an[31:0], 16'd0} | (an[32] ? {1'b1, 47'd0} : '0);
			d_q <= mag33(den);
			rem_q <= '0;
			qt_q <= '0;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial;
				qt_q <= {qt_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], n_q[NW-1]};
				qt_q <= {qt_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: src/gauss_jordan_linear_solver_top.sv
// gauss-jordan solver with partial pivoting over a matrix held in one memory
// depends on gjls_pkg, gjls_div
//
// channel | signals                                    | direction
// input   | start, busy, element_value                 | in (transfer when start & !busy)
// result  | solution_valid, solution_value, row_index, last_row | out (one cycle)
// config  | cfg_we, cfg_index, cfg_data                | in
//
// elements load at one per cycle; the last one starts the solve, busy stays high.
// per pivot column: read, compare per searched row; read, read, write per swapped word
// over all columns; read, serial divider start, wait per divided word; read, multiply,
// write per multiply-subtract word. one result per row, the last as busy falls.
// the receiver cannot stall; reset clears control only, every entry read is loaded first.
`default_nettype none
module gauss_jordan_linear_solver_top
	import gjls_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] element_value,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    solution_valid,
	output logic signed [31:0]      solution_value,
	output logic [3:0]              row_index,
	output logic                    last_row
);
	logic [4:0]  rows_q;
	logic [5:0]  cols_q;
	logic [15:0] thr_q;
	logic [RowW:0] n;
	logic [ColW:0] m;
	logic [ColW:0] lastc;

	// clamped sizes
	always_comb begin
		n = (rows_q == 5'd0) ? (RowW+1)'(1) : (rows_q > 5'(MaxRows)) ?
			(RowW+1)'(MaxRows) : rows_q[RowW:0];
		m = (cols_q < 6'd2) ? (ColW+1)'(2) : (cols_q > 6'(MaxCols)) ?
			(ColW+1)'(MaxCols) : cols_q[ColW:0];
		lastc = ({1'b0, n} < m - (ColW+1)'(1)) ? (ColW+1)'(n) : m - (ColW+1)'(1);
	end

	// matrix store
	logic signed [31:0] mem [MaxRows*MaxCols];
	logic               we;
	logic [AddrW-1:0]   wa, ra;
	logic signed [31:0] wd, rd_q;
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	gjls_state_t st_q, st_d;
	logic [RowW-1:0] lr_q, lc_q;
	logic [ColW-1:0] lcc_q;
	logic [ColW-1:0] ci_q, cj_q;
	logic [RowW:0]   r_q;
	logic [RowW-1:0] best_q;
	logic [32:0]     bmag_q;
	logic signed [31:0] fac_q, piv_q, tmp_q;
	logic signed [63:0] prod_s2, pq;
	logic            div_go, div_done;
	logic signed [31:0] div_q;
	logic [32:0]     thr33;
	logic [ColW:0]   cj_next;
	logic            swap_pend_q;
	logic [AddrW-1:0] swap_a_q;

	assign thr33 = {17'd0, thr_q};
	assign cj_next = {1'b0, cj_q} + (ColW+1)'(1);

	gjls_div u_div (.clk(clk), .arst_n(arst_n), .go(div_go), .num(rd_q), .den(piv_q),
		.done(div_done), .quo(div_q));

	function automatic logic [AddrW-1:0] adr(input logic [RowW-1:0] r,
		input logic [ColW-1:0] c);
		return {r, c};
	endfunction

	assign busy = (st_q != ST_LOAD);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD:
				if (start && {1'b0, lr_q} == n - (RowW+1)'(1) &&
					{1'b0, lcc_q} == m - (ColW+1)'(1) && !cfg_we)
					st_d = ST_COL;
			ST_COL: st_d = ({1'b0, ci_q} < lastc) ? ST_SRCH_RD : ST_OUT_RD;
			ST_SRCH_RD: st_d = ST_SRCH;
			ST_SRCH: st_d = (r_q + (RowW+1)'(1) < n) ? ST_SRCH_RD : ST_PIV;
			ST_PIV: st_d = (bmag_q < thr33) ? ST_COL : ST_SWAP_RD;
			ST_SWAP_RD: st_d = ST_SWAP_A;
			ST_SWAP_A: st_d = ST_SWAP_B;
			ST_SWAP_B: st_d = (cj_next < m) ? ST_SWAP_RD : ST_DIAG_RD;
			ST_DIAG_RD: st_d = ST_DIAG;
			ST_DIAG: st_d = (mag33(rd_q) > thr33 && rd_q != 0) ? ST_DIV_RD : ST_ROW;
			ST_DIV_RD: st_d = ST_DIV_GO;
			ST_DIV_GO: st_d = ST_DIV_WAIT;
			ST_DIV_WAIT:
				if (div_done) st_d = (cj_next < m) ? ST_DIV_RD : ST_ROW;
			ST_ROW:
				if (r_q >= n) st_d = ST_COL;
				else if (r_q[RowW-1:0] == ci_q[RowW-1:0] && {1'b0, ci_q} < (ColW+1)'(MaxRows))
					st_d = ST_ROW;
				else st_d = ST_FAC_RD;
			ST_FAC_RD: st_d = ST_FAC;
			ST_FAC: st_d = (mag33(rd_q) <= thr33) ? ST_ROW : ST_MS_RD;
			ST_MS_RD: st_d = ST_MS_MUL;
			ST_MS_MUL: st_d = ST_MS_WR;
			ST_MS_WR: st_d = (cj_next < m) ? ST_MS_RD : ST_ROW;
			ST_OUT_RD: st_d = ST_OUT;
			ST_OUT: st_d = (r_q + (RowW+1)'(1) < n) ? ST_OUT_RD : ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	// memory access and outputs
	always_comb begin
		we = 1'b0;
		wa = adr(lr_q, lcc_q);
		wd = element_value;
		ra = adr(r_q[RowW-1:0], ci_q);
		div_go = 1'b0;
		unique case (st_q)
			ST_LOAD: we = start;
			ST_SRCH_RD: ra = adr(r_q[RowW-1:0], ci_q);
			ST_SWAP_RD: ra = adr(ci_q[RowW-1:0], cj_q);
			ST_SWAP_A: begin
				ra = adr(best_q, cj_q);
			end
			ST_SWAP_B: begin
				we = 1'b1; wa = adr(ci_q[RowW-1:0], cj_q); wd = rd_q;
			end
			ST_DIAG_RD: ra = adr(ci_q[RowW-1:0], ci_q);
			ST_DIV_RD: ra = adr(ci_q[RowW-1:0], cj_q);
			ST_DIV_GO: div_go = 1'b1;
			ST_DIV_WAIT: begin
				we = div_done; wa = adr(ci_q[RowW-1:0], cj_q); wd = div_q;
			end
			ST_FAC_RD: ra = adr(r_q[RowW-1:0], ci_q);
			ST_MS_RD: ra = adr(ci_q[RowW-1:0], cj_q);
			ST_MS_MUL: ra = adr(r_q[RowW-1:0], cj_q);
			ST_MS_WR: begin
				we = 1'b1; wa = adr(r_q[RowW-1:0], cj_q);
				wd = sat32(64'(rd_q) - pq);
			end
			ST_OUT_RD: ra = adr(r_q[RowW-1:0], ColW'(m - (ColW+1)'(1)));
			default: ;
		endcase
		// second half of a swap, in the cycle after ST_SWAP_B: row best takes the saved row i word
		if (swap_pend_q) begin
			we = 1'b1; wa = swap_a_q; wd = tmp_q;
		end
	end

	// truncated product quotient: (f*p)/65536 toward zero
	assign pq = (prod_s2 < 0) ? -((-prod_s2) >>> 16) : (prod_s2 >>> 16);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			rows_q <= 5'd4; cols_q <= 6'd5; thr_q <= 16'd1;
			lr_q <= '0; lcc_q <= '0;
			ci_q <= '0; cj_q <= '0; r_q <= '0;
			solution_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			solution_valid <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					ci_q <= '0;
					if (cfg_we) begin
						if (cfg_index == RegRows) rows_q <= cfg_data[4:0];
						else if (cfg_index == RegCols) cols_q <= cfg_data[5:0];
						else if (cfg_index == RegThr) thr_q <= cfg_data;
						if (cfg_index == RegRows || cfg_index == RegCols ||
							cfg_index == RegThr) begin
							lr_q <= '0; lcc_q <= '0;
						end
					end else if (start) begin
						if ({1'b0, lcc_q} == m - (ColW+1)'(1)) begin
							lcc_q <= '0;
							lr_q <= ({1'b0, lr_q} == n - (RowW+1)'(1)) ? '0 :
								lr_q + RowW'(1);
						end else lcc_q <= lcc_q + ColW'(1);
					end
				end
				ST_COL: begin
					r_q <= ({1'b0, ci_q} < lastc) ? (RowW+1)'(ci_q) : '0;
					bmag_q <= '0; best_q <= ci_q[RowW-1:0];
				end
				ST_SRCH: begin
					if (mag33(rd_q) > bmag_q || r_q == (RowW+1)'(ci_q)) begin
						bmag_q <= mag33(rd_q); best_q <= r_q[RowW-1:0];
					end
					r_q <= r_q + (RowW+1)'(1);
				end
				ST_PIV: begin
					cj_q <= '0;
					if (bmag_q < thr33) ci_q <= ci_q + ColW'(1);
				end
				ST_SWAP_A: tmp_q <= rd_q;
				ST_SWAP_B: cj_q <= cj_next[ColW-1:0];
				ST_DIAG: begin
					piv_q <= rd_q; cj_q <= ci_q; r_q <= '0;
				end
				ST_DIV_WAIT:
					if (div_done) begin
						cj_q <= cj_next[ColW-1:0];
						r_q <= '0;
					end
				ST_ROW:
					if (r_q >= n) ci_q <= ci_q + ColW'(1);
					else if (r_q[RowW-1:0] == ci_q[RowW-1:0]) r_q <= r_q + (RowW+1)'(1);
				ST_FAC: begin
					fac_q <= rd_q; cj_q <= ci_q;
					if (mag33(rd_q) <= thr33) r_q <= r_q + (RowW+1)'(1);
				end
				ST_MS_WR:
					if (cj_next < m) cj_q <= cj_next[ColW-1:0];
					else r_q <= r_q + (RowW+1)'(1);
				ST_OUT: begin
					solution_valid <= 1'b1;
					r_q <= r_q + (RowW+1)'(1);
				end
				default: ;
			endcase
		end
	end

	// pending second swap write and its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) swap_pend_q <= 1'b0;
		else swap_pend_q <= (st_q == ST_SWAP_B);
	end
	always_ff @(posedge clk) begin
		swap_a_q <= adr(best_q, cj_q);
	end

	// multiply stage: factor times pivot row word, registered
	always_ff @(posedge clk) begin
		if (st_q == ST_MS_MUL) prod_s2 <= 64'(fac_q) * 64'(rd_q);
		if (st_q == ST_OUT) begin
			solution_value <= rd_q;
			row_index <= 4'(r_q);
			last_row <= (r_q + (RowW+1)'(1) == n);
		end
	end
endmodule
`default_nettype wire

// File: src/gjls_checker.sv
// port-level checks for the solver
// depends on gauss_jordan_linear_solver_top
`default_nettype none
module gjls_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic solution_valid,
	input wire logic last_row
);
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		solution_valid && !last_row |-> busy) else $error("result outside solve");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		solution_valid && last_row |=> !solution_valid) else $error("result after last");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		solution_valid |=> !solution_valid) else $error("results back to back");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		solution_valid && last_row |-> !busy) else $error("busy after last result");
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("solve without transfer");
endmodule
bind gauss_jordan_linear_solver_top gjls_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .solution_valid(solution_valid), .last_row(last_row));
`default_nettype wire

// File: bench/tb.sv
// self-checking bench for gauss_jordan_linear_solver_top: loads matrices, predicts the
// reduced right-hand column with an in-bench fixed-point solver, checks every result
// depends on gjls_pkg and gauss_jordan_linear_solver_top
`default_nettype none
module tb;
	import gjls_pkg::*;

	localparam logic [1:0] RegNone = 2'd3;

	typedef struct {
		logic signed [31:0] value;
		logic [3:0]         row;
		logic               last;
	} solution_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] element_value = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = RegRows;
	logic [15:0] cfg_data = '0;
	logic solution_valid;
	logic signed [31:0] solution_value;
	logic [3:0] row_index;
	logic last_row;

	gauss_jordan_linear_solver_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.element_value(element_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .solution_valid(solution_valid),
		.solution_value(solution_value), .row_index(row_index), .last_row(last_row)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [4:0]  rows_reg = 5'd4;
	logic [5:0]  cols_reg = 6'd5;
	logic [15:0] thr_reg = 16'd1;
	int          load_pos = 0;
	logic signed [31:0] mat [MaxRows][MaxCols];

	logic [31:0] elem_q [$];
	solution_t   solution_q [$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int matrices = 0;
	int gap = 0;
	bit gaps_on = 1'b1;

	function automatic longint absval(input logic signed [31:0] v);
		longint w;
		w = longint'(v);
		return w < 0 ? -w : w;
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic int rows_used();
		if (rows_reg < 1) return 1;
		if (rows_reg > MaxRows) return MaxRows;
		return rows_reg;
	endfunction

	function automatic int cols_used();
		if (cols_reg < 2) return 2;
		if (cols_reg > MaxCols) return MaxCols;
		return cols_reg;
	endfunction

	// column-by-column reduction with partial pivoting
	task automatic reduce_matrix(input int n, input int m);
		longint thr, bmag, a, p;
		int last, best;
		logic signed [31:0] prow [MaxCols];
		logic signed [31:0] tmp, dv, f;
		thr = longint'(thr_reg);
		last = (n < m - 1) ? n : m - 1;
		for (int i = 0; i < last; i++) begin
			best = i;
			bmag = -1;
			for (int r = i; r < n; r++) begin
				a = absval(mat[r][i]);
				if (a > bmag) begin
					bmag = a;
					best = r;
				end
			end
			// small pivot: skip the column
			if (bmag < thr) continue;
			if (best != i) begin
				for (int j = 0; j < MaxCols; j++) begin
					tmp = mat[i][j];
					mat[i][j] = mat[best][j];
					mat[best][j] = tmp;
				end
			end
			// pivot equal to threshold: swapped but not divided
			dv = mat[i][i];
			if (absval(dv) > thr && dv != 0) begin
				for (int j = i; j < m; j++)
					mat[i][j] = clip32((longint'(mat[i][j]) * 65536) / longint'(dv));
			end
			for (int j = 0; j < MaxCols; j++) prow[j] = mat[i][j];
			for (int r = 0; r < n; r++) begin
				if (r == i) continue;
				f = mat[r][i];
				if (absval(f) <= thr) continue;
				for (int j = i; j < m; j++) begin
					p = (longint'(f) * longint'(prow[j])) / 65536;
					mat[r][j] = clip32(longint'(mat[r][j]) - p);
				end
			end
		end
	endtask

	// one loaded element; a full matrix yields one solution per row
	task automatic load_element(input logic signed [31:0] v);
		int n, m;
		solution_t s;
		n = rows_used();
		m = cols_used();
		if (load_pos >= n * m) load_pos = 0;
		mat[load_pos / m][load_pos % m] = v;
		load_pos++;
		if (load_pos < n * m) return;
		load_pos = 0;
		matrices++;
		reduce_matrix(n, m);
		for (int r = 0; r < n; r++) begin
			s.value = mat[r][m - 1];
			s.row = r[3:0];
			s.last = (r == n - 1);
			solution_q.push_back(s);
		end
	endtask

	function automatic int next_gap();
		int k;
		if (!gaps_on) return 0;
		k = $urandom_range(0, 9);
		if (k < 6) return 0;
		if (k < 9) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// driver: feeds elements from the pending queue
	always @(posedge clk) begin : drive
		logic go;
		logic signed [31:0] val;
		go = start;
		val = element_value;
		if (start && !busy) begin
			void'(elem_q.pop_front());
			go = 1'b0;
			gap = next_gap();
		end
		if (!go) begin
			if (gap > 0) gap--;
			else if (elem_q.size() > 0 && arst_n) begin
				go = 1'b1;
				val = elem_q[0];
			end
		end
		start <= go;
		element_value <= val;
	end

	// monitor: predicts on each input transfer, checks each result transfer
	always @(posedge clk) begin : watch
		solution_t s;
		if (arst_n && start && !busy) begin
			items_sent++;
			load_element(element_value);
		end
		if (arst_n && solution_valid) begin
			results_seen++;
			if (solution_q.size() == 0) begin
				$error("unexpected result row %0d value %h", row_index, solution_value);
				errors++;
			end else begin
				s = solution_q.pop_front();
				if (solution_value !== s.value) begin
					$error("solution_value expected %h actual %h", s.value, solution_value);
					errors++;
				end
				if (row_index !== s.row) begin
					$error("row_index expected %0d actual %0d", s.row, row_index);
					errors++;
				end
				if (last_row !== s.last) begin
					$error("last_row expected %0d actual %0d", s.last, last_row);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegRows: rows_reg = data[4:0];
			RegCols: cols_reg = data[5:0];
			RegThr:  thr_reg = data;
			default: ;
		endcase
		if (idx != RegNone) load_pos = 0;
	endtask

	// all elements transferred and all solutions back, then a settle time
	task automatic wait_idle();
		while (elem_q.size() > 0 || start || solution_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_shape(input int n, input int m, input int thr);
		write_reg(RegRows, 16'(n));
		write_reg(RegCols, 16'(m));
		write_reg(RegThr, 16'(thr));
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
			1: return 32'h0;
			2, 3: return $urandom;
			4: return 32'($urandom_range(0, 4)) - 32'd2;
			default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
		endcase
	endfunction

	function automatic void push_random_matrix(input int n, input int m);
		for (int k = 0; k < n * m; k++) elem_q.push_back(rand_elem());
	endfunction

	// directed stimulus, then configuration sweep, then random phases
	initial begin : stim
		int n, m;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset shape 4x5: pivot equal to threshold, zero column, small factors
		gaps_on = 1'b0;
		elem_q = '{32'h1, 32'h0, 32'h0, 32'h10000, 32'h50000,
			32'h0, 32'h0, 32'h20000, 32'h0, 32'hfffd0000,
			32'hffffffff, 32'h0, 32'h0, 32'h30000, 32'h7fffffff,
			32'h0, 32'h0, 32'h8000, 32'h80000000, 32'h12345};
		wait_idle();

		// single equation at the value extremes, zero threshold
		gaps_on = 1'b1;
		set_shape(1, 2, 0);
		elem_q = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
		wait_idle();

		// out-of-range register values clamp; unused index changes nothing
		write_reg(RegRows, 16'd0);
		write_reg(RegCols, 16'd1);
		write_reg(RegThr, 16'hffff);
		write_reg(RegNone, 16'hffff);
		push_random_matrix(1, 2);
		wait_idle();

		// partial load is abandoned by a register write
		set_shape(3, 4, 1);
		push_random_matrix(1, 5);
		wait_idle();
		write_reg(RegThr, 16'd16);
		push_random_matrix(3, 4);
		wait_idle();

		// most rows and most columns, each reached via clamping
		set_shape(31, 2, 100);
		push_random_matrix(16, 2);
		wait_idle();
		set_shape(1, 63, 65535);
		push_random_matrix(1, 32);
		wait_idle();

		// random phases: small shapes, mostly with random gaps, some without gaps
		while (items_sent < 150) begin
			n = $urandom_range(1, 5);
			m = $urandom_range(2, 6);
			gaps_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: set_shape(n, m, 0);
				1: set_shape(n, m, $urandom_range(0, 65535));
				default: set_shape(n, m, $urandom_range(1, 64));
			endcase
			repeat ($urandom_range(1, 2)) push_random_matrix(n, m);
			wait_idle();
		end

		$display("%0d elements in %0d matrices loaded, %0d solutions checked,",
			items_sent, matrices, results_seen);
		$display("up to 16 rows and up to 32 columns, thresholds from zero to full scale");
		if (errors == 0 && solution_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#200000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
src/gjls_pkg.sv
src/gjls_div.sv
src/gauss_jordan_linear_solver_top.sv
src/gjls_checker.sv
bench/tb.sv
